// File: rtl/sfer_pkg.sv
// ----------------------------------------------------------------------------
// sfer_pkg
// shared types and constants for the sync frame echo responder
// ----------------------------------------------------------------------------
package sfer_pkg;

   localparam logic [7:0] SYNC_FIRST = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] TAIL_FIRST = 8'hAB;
   localparam logic [7:0] TAIL_SECOND = 8'hAC;

   localparam int unsigned HEADER_BYTES = 11;
   localparam int unsigned MIN_FRAME_LEN = 15;
   localparam int unsigned RSP_PREFIX_BYTES = 10;

   localparam logic [0:0] OP_BYTE = 1'b0;
   localparam logic [0:0] OP_TICK = 1'b1;

   localparam logic [0:0] CSR_MAX_LEN = 1'd0;
   localparam logic [0:0] CSR_IDLE_TIMEOUT = 1'd1;

   localparam logic [2:0] ST_BYTE = 3'd0;
   localparam logic [2:0] ST_BAD_TAIL = 3'd1;
   localparam logic [2:0] ST_BAD_LEN = 3'd2;
   localparam logic [2:0] ST_TIMEOUT = 3'd3;
   localparam logic [2:0] ST_BUSY = 3'd4;

   typedef struct packed {
      logic       valid;
      logic [7:0] tx_byte;
      logic       last_byte;
      logic [2:0] status;
   } result_type;

   typedef struct packed {
      logic [10:0] max_packet_len;
      logic [31:0] idle_timeout_ticks;
   } config_type;

endpackage

// File: rtl/sfer_core.sv
// ----------------------------------------------------------------------------
// sfer_core
// frame parser, payload buffer and response sequencer, one step per transfer
// ----------------------------------------------------------------------------
module sfer_core
   import sfer_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [0:0] opcode,
   input  logic [7:0] rx_byte,
   input  config_type cfg,
   output result_type result
);

   localparam int AW = $clog2(PAYLOAD_DEPTH);
   localparam logic [31:0] LEN_CAP = 32'(PAYLOAD_DEPTH + 15);

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_HEADER,
      PH_PAYLOAD,
      PH_TAIL1,
      PH_TAIL2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [10:0] cnt_ff, cnt_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] key_ff, key_in;
   logic [7:0]  tail_ff, tail_in;
   logic        pend_ff, pend_in;
   logic [10:0] ridx_ff, ridx_in;
   logic [31:0] idle_ff, idle_in;

   logic [7:0]    mem [PAYLOAD_DEPTH];
   logic [7:0]    rd_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;

   logic [10:0] rlen;
   logic [10:0] plen;
   logic [10:0] ridx_next;
   logic        rsp_last;
   logic [7:0]  rsp_byte;
   logic        len_bad;

   assign rlen = len_ff[10:0] - 11'd3;
   assign plen = len_ff[10:0] - 11'(MIN_FRAME_LEN);
   assign ridx_next = ridx_ff + 11'd1;
   assign rsp_last = (ridx_next >= rlen);
   assign len_bad = (len_ff < 32'(MIN_FRAME_LEN)) || (len_ff > {21'd0, cfg.max_packet_len})
                    || (len_ff > LEN_CAP);
   assign wr_addr = AW'(cnt_ff);

   always_comb begin
      if (ridx_ff == 11'd0) begin
         rsp_byte = SYNC_FIRST;
      end else if (ridx_ff == 11'd1) begin
         rsp_byte = SYNC_SECOND;
      end else if (ridx_ff == 11'd2) begin
         rsp_byte = rlen[7:0];
      end else if (ridx_ff == 11'd3) begin
         rsp_byte = {5'd0, rlen[10:8]};
      end else if (ridx_ff < 11'd6) begin
         rsp_byte = 8'd0;
      end else if (ridx_ff == 11'd6) begin
         rsp_byte = key_ff[7:0];
      end else if (ridx_ff == 11'd7) begin
         rsp_byte = key_ff[15:8];
      end else if (ridx_ff < 11'(RSP_PREFIX_BYTES)) begin
         rsp_byte = 8'd0;
      end else if (ridx_ff < 11'(RSP_PREFIX_BYTES) + plen) begin
         rsp_byte = rd_ff;
      end else if (ridx_ff == rlen - 11'd2) begin
         rsp_byte = TAIL_FIRST;
      end else begin
         rsp_byte = TAIL_SECOND;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      key_in = key_ff;
      tail_in = tail_ff;
      pend_in = pend_ff;
      ridx_in = ridx_ff;
      idle_in = idle_ff;
      wr_en = 1'b0;
      result = '0;
      if (step_en) begin
         if (opcode == OP_TICK) begin
            if (pend_ff) begin
               result.valid = 1'b1;
               result.tx_byte = rsp_byte;
               result.last_byte = rsp_last;
               result.status = ST_BYTE;
               if (rsp_last) begin
                  pend_in = 1'b0;
                  ridx_in = 11'd0;
               end else begin
                  ridx_in = ridx_next;
               end
            end else if (phase_ff == PH_HUNT1 || cfg.idle_timeout_ticks == 32'd0) begin
               idle_in = 32'd0;
            end else begin
               idle_in = idle_ff + 32'd1;
               if (({1'b0, idle_ff} + 33'd1) >= {1'b0, cfg.idle_timeout_ticks}) begin
                  phase_in = PH_HUNT1;
                  cnt_in = 11'd0;
                  idle_in = 32'd0;
                  result.valid = 1'b1;
                  result.status = ST_TIMEOUT;
               end
            end
         end else if (pend_ff) begin
            result.valid = 1'b1;
            result.status = ST_BUSY;
         end else begin
            idle_in = 32'd0;
            unique case (phase_ff)
               PH_HUNT1: begin
                  if (rx_byte == SYNC_FIRST) begin
                     phase_in = PH_HUNT2;
                  end
               end
               PH_HUNT2: begin
                  if (rx_byte == SYNC_SECOND) begin
                     phase_in = PH_HEADER;
                     cnt_in = 11'd0;
                     len_in = 32'd0;
                     key_in = 16'd0;
                  end else if (rx_byte != SYNC_FIRST) begin
                     phase_in = PH_HUNT1;
                  end
               end
               PH_HEADER: begin
                  case (cnt_ff)
                     11'd0: len_in[7:0] = len_ff[7:0] | rx_byte;
                     11'd1: len_in[15:8] = len_ff[15:8] | rx_byte;
                     11'd2: len_in[23:16] = len_ff[23:16] | rx_byte;
                     11'd3: len_in[31:24] = len_ff[31:24] | rx_byte;
                     11'd4: key_in[7:0] = key_ff[7:0] | rx_byte;
                     11'd5: key_in[15:8] = key_ff[15:8] | rx_byte;
                     default: ;
                  endcase
                  cnt_in = cnt_ff + 11'd1;
                  if (cnt_ff == 11'(HEADER_BYTES - 1)) begin
                     cnt_in = 11'd0;
                     if (len_bad) begin
                        phase_in = PH_HUNT1;
                        result.valid = 1'b1;
                        result.status = ST_BAD_LEN;
                     end else if (len_ff == 32'(MIN_FRAME_LEN)) begin
                        phase_in = PH_TAIL1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  wr_en = 1'b1;
                  cnt_in = cnt_ff + 11'd1;
                  if ((cnt_ff + 11'd1) >= plen) begin
                     phase_in = PH_TAIL1;
                  end
               end
               PH_TAIL1: begin
                  tail_in = rx_byte;
                  phase_in = PH_TAIL2;
               end
               PH_TAIL2: begin
                  phase_in = PH_HUNT1;
                  cnt_in = 11'd0;
                  if (tail_ff != TAIL_FIRST || rx_byte != TAIL_SECOND) begin
                     result.valid = 1'b1;
                     result.status = ST_BAD_TAIL;
                  end else begin
                     pend_in = 1'b1;
                     ridx_in = 11'd0;
                  end
               end
               default: begin
                  phase_in = PH_HUNT1;
               end
            endcase
         end
      end
   end

   // prefetch the payload byte for the next response index
   assign rd_addr = (ridx_in < 11'(RSP_PREFIX_BYTES)) ? '0
                    : AW'(ridx_in - 11'(RSP_PREFIX_BYTES));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= rx_byte;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         cnt_ff <= '0;
         len_ff <= '0;
         key_ff <= '0;
         tail_ff <= '0;
         pend_ff <= 1'b0;
         ridx_ff <= '0;
         idle_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         len_ff <= len_in;
         key_ff <= key_in;
         tail_ff <= tail_in;
         pend_ff <= pend_in;
         ridx_ff <= ridx_in;
         idle_ff <= idle_in;
      end
   end

endmodule

// File: rtl/sync_frame_echo_responder_top.sv
// ----------------------------------------------------------------------------
// sync_frame_echo_responder_top
// sync framed receiver that echoes good frames back one byte per tick
// ----------------------------------------------------------------------------
//  channel   direction  ports                                       handshake
//  req       in         req_opcode, req_rx_byte                     valid/ready
//  rsp       out        rsp_tx_byte, rsp_last_byte, rsp_status      valid/ready
//  csr       in         csr_index, csr_wr_data                      csr_wr_en
//
//  one request transfer per cycle while req_ready is high; its result is in
//  the output register the next cycle. the payload buffer read is prefetched
//  ahead of use. req_ready drops only while a result waits and rsp_ready is low.
//  synchronous reset; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module sync_frame_echo_responder_top
   import sfer_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [0:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   config_type cfg_ff;
   result_type result;
   logic       step_en;
   logic       rsp_valid_ff;
   logic [7:0] tx_byte_ff;
   logic       last_byte_ff;
   logic [2:0] status_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step_en = req_valid && req_ready;

   sfer_core #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .opcode(req_opcode),
      .rx_byte(req_rx_byte),
      .cfg(cfg_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_packet_len <= 11'd1039;
         cfg_ff.idle_timeout_ticks <= 32'd60000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_LEN: cfg_ff.max_packet_len <= csr_wr_data[10:0];
            CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout_ticks <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         tx_byte_ff <= result.tx_byte;
         last_byte_ff <= result.last_byte;
         status_ff <= result.status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tx_byte = tx_byte_ff;
   assign rsp_last_byte = last_byte_ff;
   assign rsp_status = status_ff;

endmodule

// File: rtl/sfer_checker.sv
// ----------------------------------------------------------------------------
// sfer_checker
// port level checks on the result channel of the responder
// ----------------------------------------------------------------------------
module sfer_checker
   import sfer_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last_byte,
   input logic [2:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_status))
      else $error("stalled transfer changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_flag_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BYTE |-> rsp_tx_byte == 8'd0 && !rsp_last_byte)
      else $error("flag carries data");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_BUSY)
      else $error("unknown status");

   a_last_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte |-> rsp_tx_byte == TAIL_SECOND && rsp_status == ST_BYTE)
      else $error("last byte is not the tail");

endmodule

bind sync_frame_echo_responder_top sfer_checker u_sfer_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_tx_byte(rsp_tx_byte),
   .rsp_last_byte(rsp_last_byte),
   .rsp_status(rsp_status)
);

// File: sim/sfer_echo_checker.sv
// ----------------------------------------------------------------------------
// sfer_echo_checker
// watches the request, response and register ports of the echo responder,
// tracks the frame parser and the pending echo on every request transfer,
// and compares each response transfer with the oldest predicted result
// ----------------------------------------------------------------------------
module sfer_echo_checker
   import sfer_pkg::*;
#(
   parameter int         PAYLOAD_DEPTH      = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [0:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_last_byte,
   input  logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wr_data,
   output int          error_count,
   output int          awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [10:0] RESET_MAX_LEN = 11'd1039;
   localparam logic [31:0] RESET_IDLE_LIMIT = 32'd60000;
   localparam int unsigned TAIL_BYTES = 2;
   localparam int unsigned ECHO_SHRINK = MIN_FRAME_LEN - RSP_PREFIX_BYTES - TAIL_BYTES;

   typedef enum logic [2:0] {
      HUNT_SYNC_FIRST,
      HUNT_SYNC_SECOND,
      READ_HEADER,
      READ_PAYLOAD,
      READ_TAIL_FIRST,
      READ_TAIL_SECOND
   } rx_phase_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic [2:0] status;
   } echo_result_type;

   echo_result_type echo_expected[$];
   echo_result_type oldest;

   rx_phase_type rx_phase;
   int unsigned  rx_count;
   logic [31:0]  frame_len;
   logic [15:0]  frame_key;
   logic [7:0]   tail_seen;
   logic [7:0]   payload_mem [PAYLOAD_DEPTH];
   logic         echo_pending;
   int unsigned  echo_index;
   logic [31:0]  idle_count;
   logic [10:0]  max_len_reg;
   logic [31:0]  idle_limit_reg;
   int           errors;

   task automatic note(input logic [7:0] b, input logic l, input logic [2:0] s);
      echo_expected.push_back('{tx_byte: b, last_byte: l, status: s});
   endtask

   task automatic restart_hunt();
      rx_phase = HUNT_SYNC_FIRST;
      rx_count = 0;
      idle_count = '0;
   endtask

   function automatic logic [7:0] echo_byte(input int unsigned idx, input logic [31:0] rsp_len);
      logic [31:0] body_len;
      logic [31:0] shifted;
      body_len = rsp_len - RSP_PREFIX_BYTES - TAIL_BYTES;
      shifted = rsp_len >> (8 * (idx - 2));
      if (idx == 0) return SYNC_FIRST;
      if (idx == 1) return SYNC_SECOND;
      if (idx < 6) return shifted[7:0];
      if (idx == 6) return frame_key[7:0];
      if (idx == 7) return frame_key[15:8];
      if (idx < RSP_PREFIX_BYTES) return 8'h00;
      if (idx < RSP_PREFIX_BYTES + body_len)
         return payload_mem[(idx - RSP_PREFIX_BYTES) % PAYLOAD_DEPTH];
      if (idx == rsp_len - TAIL_BYTES) return TAIL_FIRST;
      return TAIL_SECOND;
   endfunction

   task automatic take_tick();
      logic [31:0] rsp_len;
      logic        last;
      if (echo_pending) begin
         rsp_len = frame_len - ECHO_SHRINK;
         last = (echo_index + 1 >= rsp_len);
         note(echo_byte(echo_index, rsp_len), last, ST_BYTE);
         if (last) begin
            echo_pending = 1'b0;
            echo_index = 0;
         end else begin
            echo_index = echo_index + 1;
         end
      end else if (rx_phase == HUNT_SYNC_FIRST || idle_limit_reg == 0) begin
         idle_count = '0;
      end else begin
         idle_count = idle_count + 1;
         if (idle_count >= idle_limit_reg) begin
            restart_hunt();
            note(8'h00, 1'b0, ST_TIMEOUT);
         end
      end
   endtask

   task automatic take_rx(input logic [7:0] b);
      int unsigned lim;
      idle_count = '0;
      case (rx_phase)
         HUNT_SYNC_FIRST: begin
            if (b == SYNC_FIRST) rx_phase = HUNT_SYNC_SECOND;
         end
         HUNT_SYNC_SECOND: begin
            if (b == SYNC_SECOND) begin
               rx_phase = READ_HEADER;
               rx_count = 0;
               frame_len = '0;
               frame_key = '0;
            end else if (b != SYNC_FIRST) begin
               rx_phase = HUNT_SYNC_FIRST;
            end
         end
         READ_HEADER: begin
            if (rx_count < 4)
               frame_len = frame_len | ({24'd0, b} << (8 * rx_count));
            else if (rx_count < 6)
               frame_key = frame_key | ({8'd0, b} << (8 * (rx_count - 4)));
            rx_count = rx_count + 1;
            if (rx_count == HEADER_BYTES) begin
               lim = 32'(max_len_reg);
               if (lim > PAYLOAD_DEPTH + MIN_FRAME_LEN) lim = PAYLOAD_DEPTH + MIN_FRAME_LEN;
               if (frame_len < MIN_FRAME_LEN || frame_len > lim) begin
                  restart_hunt();
                  note(8'h00, 1'b0, ST_BAD_LEN);
               end else begin
                  rx_count = 0;
                  rx_phase = (frame_len == MIN_FRAME_LEN) ? READ_TAIL_FIRST : READ_PAYLOAD;
               end
            end
         end
         READ_PAYLOAD: begin
            payload_mem[rx_count % PAYLOAD_DEPTH] = b;
            rx_count = rx_count + 1;
            if (rx_count >= frame_len - MIN_FRAME_LEN) rx_phase = READ_TAIL_FIRST;
         end
         READ_TAIL_FIRST: begin
            tail_seen = b;
            rx_phase = READ_TAIL_SECOND;
         end
         default: begin
            restart_hunt();
            if (tail_seen != TAIL_FIRST || b != TAIL_SECOND) begin
               note(8'h00, 1'b0, ST_BAD_TAIL);
            end else begin
               echo_pending = 1'b1;
               echo_index = 0;
            end
         end
      endcase
   endtask

   task automatic check_field(input string field, input int unsigned wanted,
                              input int unsigned seen);
      if (wanted != seen) begin
         errors++;
         $display("%0t %s mismatch: expected %0h actual %0h", $time, field, wanted, seen);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         echo_expected.delete();
         max_len_reg = RESET_MAX_LEN;
         idle_limit_reg = RESET_IDLE_LIMIT;
         rx_phase = HUNT_SYNC_FIRST;
         rx_count = 0;
         frame_len = '0;
         frame_key = '0;
         tail_seen = '0;
         echo_pending = 1'b0;
         echo_index = 0;
         idle_count = '0;
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (echo_expected.size() == 0) begin
               errors++;
               $display("%0t unexpected transfer: expected none actual %02h/%0b/%0d",
                        $time, rsp_tx_byte, rsp_last_byte, rsp_status);
            end else begin
               oldest = echo_expected.pop_front();
               check_field("tx_byte", 32'(oldest.tx_byte), 32'(rsp_tx_byte));
               check_field("last_byte", 32'(oldest.last_byte), 32'(rsp_last_byte));
               check_field("status", 32'(oldest.status), 32'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_TICK) take_tick();
            else if (echo_pending) note(8'h00, 1'b0, ST_BUSY);
            else take_rx(req_rx_byte);
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_MAX_LEN) max_len_reg = csr_wr_data[10:0];
            else if (csr_index == CSR_IDLE_TIMEOUT) idle_limit_reg = csr_wr_data;
         end
      end
      error_count <= errors;
      awaited_count <= echo_expected.size();
   end

endmodule

// File: sim/tb_sync_frame_echo_responder_top.sv
// ----------------------------------------------------------------------------
// tb_sync_frame_echo_responder_top
// drives framed byte streams and ticks into the echo responder: a short
// directed pass over sync hunting, length, tail, busy and timeout cases,
// then random frames, noise and stalls under several register settings;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_sync_frame_echo_responder_top
   import sfer_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ECHO_DEPTH = 1024;
   localparam int unsigned ECHO_SHRINK = 3;
   localparam int STALL_LIMIT = 1000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [0:0]  req_opcode = OP_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;
   logic [2:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [0:0]  csr_index = CSR_MAX_LEN;
   logic [31:0] csr_wr_data = 32'd0;

   int          errors_seen;
   int          results_awaited;
   int          items_sent = 0;
   int          quiet_cycles = 0;
   bit          idle_on = 1'b0;
   bit          stray_ticks = 1'b0;
   logic [10:0] max_len_now = 11'd1039;
   logic [31:0] idle_now = 32'd60000;

   sync_frame_echo_responder_top #(.PAYLOAD_DEPTH(ECHO_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte), .rsp_last_byte(rsp_last_byte), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   sfer_echo_checker #(
      .PAYLOAD_DEPTH(ECHO_DEPTH)
   ) echo_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte), .rsp_last_byte(rsp_last_byte), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .error_count(errors_seen), .awaited_count(results_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response side stalls in bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned frame_limit();
      if (max_len_now > ECHO_DEPTH + MIN_FRAME_LEN) return ECHO_DEPTH + MIN_FRAME_LEN;
      return 32'(max_len_now);
   endfunction

   task automatic send_item(input logic [0:0] op, input logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic feed_byte(input logic [7:0] b);
      if (stray_ticks && $urandom_range(0, 15) == 0)
         repeat ($urandom_range(1, 3)) send_tick();
      send_item(OP_BYTE, b);
   endtask

   task automatic send_header(input logic [31:0] len, input logic [15:0] key);
      int i;
      feed_byte(SYNC_FIRST);
      feed_byte(SYNC_SECOND);
      for (i = 0; i < 4; i++) feed_byte(len[8*i +: 8]);
      feed_byte(key[7:0]);
      feed_byte(key[15:8]);
      // version and session id
      for (i = 0; i < 5; i++) feed_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic drain_echo(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(0, 7) == 0) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
         send_tick();
      end
   endtask

   task automatic send_frame(input logic [31:0] len, input logic [15:0] key, input bit tail_ok);
      int unsigned i;
      logic [7:0]  t0;
      logic [7:0]  t1;
      send_header(len, key);
      if (len >= MIN_FRAME_LEN && len <= frame_limit()) begin
         for (i = MIN_FRAME_LEN; i < len; i++) feed_byte(8'($urandom_range(0, 255)));
         t0 = TAIL_FIRST;
         t1 = TAIL_SECOND;
         if (!tail_ok) begin
            case ($urandom_range(0, 2))
               0: begin
                  t1 = 8'($urandom_range(0, 255));
                  if (t1 == TAIL_SECOND) t1 = ~t1;
               end
               1: begin
                  t0 = 8'($urandom_range(0, 255));
                  if (t0 == TAIL_FIRST) t0 = ~t0;
               end
               default: begin
                  t0 = TAIL_SECOND;
                  t1 = TAIL_FIRST;
               end
            endcase
         end
         feed_byte(t0);
         feed_byte(t1);
         if (tail_ok) drain_echo(len - ECHO_SHRINK);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_awaited != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MAX_LEN) max_len_now = val[10:0];
      else idle_now = val;
   endtask

   function automatic logic [31:0] good_len();
      int unsigned lim;
      int unsigned hi;
      lim = frame_limit();
      if (lim < MIN_FRAME_LEN) return MIN_FRAME_LEN + $urandom_range(0, 25);
      hi = ($urandom_range(0, 19) == 0) ? 300 : 40;
      if (hi > lim) hi = lim;
      return $urandom_range(MIN_FRAME_LEN, hi);
   endfunction

   function automatic logic [31:0] bad_len();
      case ($urandom_range(0, 2))
         0: return $urandom_range(0, MIN_FRAME_LEN - 1);
         1: return frame_limit() + $urandom_range(1, 40);
         default: return $urandom | 32'h0001_0000;
      endcase
   endfunction

   task automatic run_random(input int budget, input bit allow_idle);
      int          stop_at;
      int          pick;
      int          i;
      logic [7:0]  b;
      stop_at = items_sent + budget;
      stray_ticks = 1'b1;
      while (items_sent < stop_at) begin
         if (!allow_idle) idle_on = 1'b0;
         else if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_frame(good_len(), 16'($urandom_range(0, 65535)), 1'b1);
         end else if (pick < 65) begin
            send_frame(good_len(), 16'($urandom_range(0, 65535)), 1'b0);
         end else if (pick < 75) begin
            send_frame(bad_len(), 16'($urandom_range(0, 65535)), 1'b1);
         end else if (pick < 85 && idle_now != 0 && idle_now <= 64) begin
            // partial frame left hanging until the idle timeout fires
            send_item(OP_BYTE, SYNC_FIRST);
            if ($urandom_range(0, 1) == 1) begin
               send_item(OP_BYTE, SYNC_SECOND);
               repeat ($urandom_range(0, HEADER_BYTES - 1))
                  send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end
            repeat (idle_now + $urandom_range(0, 2)) send_tick();
         end else begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_tick();
               end else begin
                  b = 8'($urandom_range(0, 255));
                  if (b == SYNC_FIRST) b = ~b;
                  send_item(OP_BYTE, b);
               end
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_MAX_LEN, 32'd1039);
      write_reg(CSR_IDLE_TIMEOUT, 32'd6);

      // sync hunting, minimal frame with busy byte, length and tail errors, timeout
      send_tick();
      send_item(OP_BYTE, SYNC_FIRST);
      send_item(OP_BYTE, 8'h41);
      send_item(OP_BYTE, SYNC_FIRST);
      send_header(MIN_FRAME_LEN, 16'hFFFF);
      send_item(OP_BYTE, TAIL_FIRST);
      send_item(OP_BYTE, TAIL_SECOND);
      send_item(OP_BYTE, 8'h00);
      drain_echo(MIN_FRAME_LEN - ECHO_SHRINK);
      send_header(MIN_FRAME_LEN - 1, 16'h0000);
      send_header(32'd1040, 16'h8001);
      send_header(MIN_FRAME_LEN, 16'h1234);
      send_item(OP_BYTE, TAIL_FIRST);
      send_item(OP_BYTE, TAIL_FIRST);
      send_item(OP_BYTE, SYNC_FIRST);
      repeat (3) send_tick();
      send_item(OP_BYTE, SYNC_FIRST);
      repeat (6) send_tick();

      settle();
      write_reg(CSR_IDLE_TIMEOUT, 32'd12);
      run_random(90, 1'b1);

      settle();
      write_reg(CSR_MAX_LEN, MIN_FRAME_LEN);
      write_reg(CSR_IDLE_TIMEOUT, 32'd0);
      run_random(90, 1'b1);

      settle();
      write_reg(CSR_MAX_LEN, MIN_FRAME_LEN - 1);
      write_reg(CSR_IDLE_TIMEOUT, 32'd1);
      run_random(60, 1'b1);

      settle();
      write_reg(CSR_MAX_LEN, 32'd2047);
      write_reg(CSR_IDLE_TIMEOUT, 32'hFFFF_FFFF);
      idle_on = 1'b1;
      send_frame(ECHO_DEPTH + MIN_FRAME_LEN + 1, 16'($urandom_range(0, 65535)), 1'b1);
      run_random(60, 1'b1);

      settle();
      write_reg(CSR_MAX_LEN, $urandom_range(MIN_FRAME_LEN, 1039));
      write_reg(CSR_IDLE_TIMEOUT, $urandom_range(3, 30));
      run_random(140, 1'b0);

      settle();
      repeat (8) @(posedge clock);
      if (errors_seen == 0 && results_awaited == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
